/* sv/mifwd_pkg.sv */
// Shared types, widths and constants of the MAC/IP forwarding table.
`default_nettype none

package mifwd_pkg;

  // Table geometry
  localparam int TableDepth = 16;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW     = $clog2(TableDepth + 1);

  // Word field widths
  localparam int OpW     = 2;
  localparam int MacW    = 48;
  localparam int IpW     = 32;
  localparam int EtypeW  = 16;
  localparam int StatusW = 2;
  localparam int EntryW  = MacW + IpW;

  // Frame constants
  localparam logic [EtypeW-1:0] EtypeIpv4 = 16'h0800;
  localparam logic [EtypeW-1:0] EtypeArp  = 16'h0806;
  localparam logic [MacW-1:0]   MacBcast  = '1;
  localparam logic [IpW-1:0]    IpBcast   = '1;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* sv/mifwd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mifwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and read, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/mac_ip_forwarding_table_unit.sv */
// Top level of the MAC/IP forwarding table: sequencer, compare unit and binding store.
//
// Usage: drive opcode_i, mac_addr_i, ip_addr_i and ether_type_i and raise start;
// the command word is taken at the clock edge where start is high and busy is low.
// Opcodes: add binding, remove binding, forward check of a frame; the fourth code
// does nothing and only reports the current binding count.
// The block then walks the table one entry at a time through a single MAC/IP
// equality comparator. Each entry is handled in two steps (RAM read, then
// compare), and add, remove and check keep busy high through the scan and a
// final step; the unused opcode skips the scan. The result word (forward_o,
// status_o, entry_total_o) is shown for exactly one cycle with done_o high, in
// the same cycle that busy falls; a new command may be started in that same cycle.
// The receiver cannot stall: done_o is a strobe and the result is gone after it.
// Reset (rst_ni low) clears all valid bits and the binding count at once; the
// MAC/IP store itself is not cleared and is only ever read under a valid bit,
// so the block is ready in the first cycle after reset.
`default_nettype none

module mac_ip_forwarding_table_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [mifwd_pkg::OpW-1:0]        opcode_i,
  input  wire logic [mifwd_pkg::MacW-1:0]       mac_addr_i,
  input  wire logic [mifwd_pkg::IpW-1:0]        ip_addr_i,
  input  wire logic [mifwd_pkg::EtypeW-1:0]     ether_type_i,
  output logic                                  done_o,
  output logic                                  forward_o,
  output logic [mifwd_pkg::StatusW-1:0]         status_o,
  output logic [mifwd_pkg::CountW-1:0]          entry_total_o
);

  import mifwd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     idx_q;
  op_e                 op_q;
  logic [MacW-1:0]     mac_q;
  logic [IpW-1:0]      ip_q;
  logic [EtypeW-1:0]   etype_q;
  logic                pair_hit_q;
  logic [IdxW-1:0]     pair_idx_q;
  logic                free_hit_q;
  logic [IdxW-1:0]     free_idx_q;
  logic                mac_hit_q;
  logic                ip_hit_q;
  logic [TableDepth-1:0] valid_q;
  logic [CountW-1:0]   count_q;
  logic                done_q;
  logic                forward_q;
  logic [StatusW-1:0]  status_q;
  logic [CountW-1:0]   total_q;

  logic                accept;
  logic [EntryW-1:0]   rd_entry;
  logic [MacW-1:0]     rd_mac;
  logic [IpW-1:0]      rd_ip;
  logic                ent_valid;
  logic                mac_eq;
  logic                ip_eq;
  logic                ram_we;
  status_e             fin_status;
  logic                fin_fwd;
  logic [CountW-1:0]   fin_count;
  logic                fin_set;
  logic                fin_clr;
  logic                is_ipv4;
  logic                is_arp;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Binding store: MAC in the upper bits, IP in the lower bits
  mifwd_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx_q),
    .wdata_i ({mac_q, ip_q}),
    .raddr_i (idx_q),
    .rdata_o (rd_entry)
  );

  // Shared compare unit: one entry per compare cycle
  assign rd_mac    = rd_entry[EntryW-1 -: MacW];
  assign rd_ip     = rd_entry[IpW-1:0];
  assign ent_valid = valid_q[idx_q];
  assign mac_eq    = ent_valid && (rd_mac == mac_q);
  assign ip_eq     = ent_valid && (rd_ip == ip_q);

  // Resolve the command once the scan is over
  assign is_ipv4 = (etype_q == EtypeIpv4);
  assign is_arp  = (etype_q == EtypeArp);

  always_comb begin
    fin_status = ST_DONE;
    fin_fwd    = 1'b0;
    fin_count  = count_q;
    fin_set    = 1'b0;
    fin_clr    = 1'b0;
    case (op_q)
      OP_ADD: begin
        if (pair_hit_q) begin
          fin_status = ST_DUP;
        end else if (free_hit_q) begin
          fin_set   = 1'b1;
          fin_count = count_q + CountW'(1);
        end else begin
          fin_status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (pair_hit_q) begin
          fin_clr   = 1'b1;
          fin_count = (count_q != '0) ? count_q - CountW'(1) : count_q;
        end else begin
          fin_status = ST_NOTFOUND;
        end
      end
      OP_CHECK: begin
        fin_fwd = (count_q != '0) && (is_ipv4 || is_arp) &&
                  ((mac_q == MacBcast) || mac_hit_q ||
                   (is_ipv4 && ((ip_q == IpBcast) || ip_hit_q)));
      end
      default: begin
        fin_status = ST_DONE;
      end
    endcase
  end

  assign ram_we = (state_q == S_FIN) && fin_set;

  // Sequencer, scan accumulators, table bookkeeping and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      idx_q      <= '0;
      pair_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      mac_hit_q  <= 1'b0;
      ip_hit_q   <= 1'b0;
      valid_q    <= '0;
      count_q    <= '0;
      done_q     <= 1'b0;
      forward_q  <= 1'b0;
      status_q   <= '0;
      total_q    <= '0;
    end else begin
      done_q <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= op_e'(opcode_i);
            mac_q      <= mac_addr_i;
            ip_q       <= ip_addr_i;
            etype_q    <= ether_type_i;
            idx_q      <= '0;
            pair_hit_q <= 1'b0;
            free_hit_q <= 1'b0;
            mac_hit_q  <= 1'b0;
            ip_hit_q   <= 1'b0;
            state_q    <= (op_e'(opcode_i) == OP_NONE) ? S_FIN : S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (mac_eq && ip_eq && !pair_hit_q) begin
            pair_hit_q <= 1'b1;
            pair_idx_q <= idx_q;
          end
          if (!ent_valid && !free_hit_q) begin
            free_hit_q <= 1'b1;
            free_idx_q <= idx_q;
          end
          mac_hit_q <= mac_hit_q || mac_eq;
          ip_hit_q  <= ip_hit_q || ip_eq;
          if (idx_q == IdxW'(TableDepth - 1)) begin
            state_q <= S_FIN;
          end else begin
            idx_q   <= idx_q + IdxW'(1);
            state_q <= S_READ;
          end
        end
        S_FIN: begin
          if (fin_set) begin
            valid_q[free_idx_q] <= 1'b1;
          end
          if (fin_clr) begin
            valid_q[pair_idx_q] <= 1'b0;
          end
          count_q   <= fin_count;
          forward_q <= fin_fwd;
          status_q  <= fin_status;
          total_q   <= fin_count;
          state_q   <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign forward_o     = forward_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;

  // Count tracks the valid bits and never exceeds the table
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CountW'($countones(valid_q)))
    else $error("binding count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth))
    else $error("binding count above table depth");

  // A taken command occupies the block until its result word
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("command taken but block not busy");

  // Result word follows the end of the sequence, one cycle only
  a_done_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_FIN) && !busy)
    else $error("result strobe without finished command");

  // Forward only on a successful check
  a_forward_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && forward_o) |-> (status_o == ST_DONE) && (entry_total_o != '0))
    else $error("forward with bad status or empty table");

endmodule

`default_nettype wire
